// ===== hdl/pcnc_pkg.sv =====
// Shared types and constants of the partition cut-node counter.
// No dependencies; every other file of the block imports this package.
package pcnc_pkg;

   localparam int NODE_W = 16;
   localparam int PART_W = 6;
   localparam int CNT_W  = 17;
   localparam int EDGE_W = 32;

   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = 2;
   localparam int RSP_CW    = 3;

   // Operation codes issued to the read-modify-write stage.
   localparam logic [1:0] OP_PASS = 2'd0;
   localparam logic [1:0] OP_MARK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [NODE_W-1:0] src_node;
      logic [NODE_W-1:0] dst_node;
      logic [PART_W-1:0] src_part;
      logic [PART_W-1:0] dst_part;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NODE_W-1:0] node;
      logic [PART_W-1:0] part;
      logic              inc_edge;
      logic              is_cut;
      logic              last;
   } op_type;

   typedef struct packed {
      logic              edge_is_cut;
      logic [EDGE_W-1:0] cut_edge_total;
      logic [CNT_W-1:0]  cut_node_total;
      logic [CNT_W-1:0]  part_count;
   } rsp_type;

endpackage

// ===== hdl/pcnc_chan_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on pcnc_pkg for field widths.
interface pcnc_req_if;
   import pcnc_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [NODE_W-1:0] src_node;
   logic [NODE_W-1:0] dst_node;
   logic [PART_W-1:0] src_part;
   logic [PART_W-1:0] dst_part;

   modport source (output valid, output req_type, output src_node, output dst_node,
                   output src_part, output dst_part, input ready);
   modport sink   (input valid, input req_type, input src_node, input dst_node,
                   input src_part, input dst_part, output ready);
endinterface

interface pcnc_rsp_if;
   import pcnc_pkg::*;

   logic              valid;
   logic              ready;
   logic              edge_is_cut;
   logic [EDGE_W-1:0] cut_edge_total;
   logic [CNT_W-1:0]  cut_node_total;
   logic [CNT_W-1:0]  part_count;

   modport source (output valid, output edge_is_cut, output cut_edge_total,
                   output cut_node_total, output part_count, input ready);
   modport sink   (input valid, input edge_is_cut, input cut_edge_total,
                   input cut_node_total, input part_count, output ready);
endinterface

// ===== hdl/pcnc_seq.sv =====
// Sequencer: holds one request beat, splits it into memory operations and
// runs the clearing pass after reset. Depends on pcnc_pkg and pcnc_req_if.
module pcnc_seq #(
   parameter int NODE_COUNT = 65536,
   parameter int PART_COUNT = 64,
   localparam int CLR_N  = (NODE_COUNT > PART_COUNT) ? NODE_COUNT : PART_COUNT,
   localparam int CLR_AW = $clog2(CLR_N)
) (
   input  logic                       clock,
   input  logic                       reset,
   pcnc_req_if.sink                   req_bus,
   input  logic [pcnc_pkg::RSP_CW-1:0] fifo_count,
   input  logic                       s1_last,
   output logic                       op_valid,
   output pcnc_pkg::op_type           op,
   output logic                       clr_en,
   output logic [CLR_AW-1:0]          clr_addr
);
   import pcnc_pkg::*;

   logic               hold_valid_ff, hold_valid_in;
   req_beat_type       hold_ff, hold_in;
   logic               phase_ff, phase_in;
   logic [CLR_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               clr_done_ff, clr_done_in;
   logic [RSP_CW:0]    occupancy;
   logic               credit_ok;
   logic               issue;
   logic               accept;

   always_comb begin
      op = '0;
      if (hold_ff.req_type) begin
         op.kind = OP_READ;
         op.part = hold_ff.src_part;
         op.last = 1'b1;
      end else if (hold_ff.src_part != hold_ff.dst_part) begin
         op.kind   = OP_MARK;
         op.is_cut = 1'b1;
         if (!phase_ff) begin
            op.node     = hold_ff.src_node;
            op.part     = hold_ff.src_part;
            op.inc_edge = 1'b1;
         end else begin
            op.node = hold_ff.dst_node;
            op.part = hold_ff.dst_part;
            op.last = 1'b1;
         end
      end else begin
         op.kind = OP_PASS;
         op.last = 1'b1;
      end
   end

   // A result may still be on its way from the update stage.
   assign occupancy = {1'b0, fifo_count} + {{RSP_CW{1'b0}}, s1_last};
   assign credit_ok = occupancy < (RSP_CW + 1)'(RSP_DEPTH);
   assign issue     = clr_done_ff && hold_valid_ff && credit_ok;
   assign op_valid  = issue;

   assign req_bus.ready = clr_done_ff && (!hold_valid_ff || (issue && op.last));
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      phase_in      = phase_ff;
      if (issue && !op.last) begin
         phase_in = 1'b1;
      end
      if (issue && op.last) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in    = 1'b1;
         phase_in         = 1'b0;
         hold_in.req_type = req_bus.req_type;
         hold_in.src_node = req_bus.src_node;
         hold_in.dst_node = req_bus.dst_node;
         hold_in.src_part = req_bus.src_part;
         hold_in.dst_part = req_bus.dst_part;
      end
   end

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         if (clr_cnt_ff == CLR_AW'(CLR_N - 1)) begin
            clr_done_in = 1'b1;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   assign clr_en   = !clr_done_ff;
   assign clr_addr = clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         clr_cnt_ff    <= '0;
         clr_done_ff   <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_done_ff   <= clr_done_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

// ===== hdl/pcnc_rmw.sv =====
// Node flag and partition counter memories with their read-modify-write
// stage, forwarding and running totals. Depends on pcnc_pkg.
module pcnc_rmw #(
   parameter int NODE_COUNT = 65536,
   parameter int PART_COUNT = 64,
   localparam int CLR_N  = (NODE_COUNT > PART_COUNT) ? NODE_COUNT : PART_COUNT,
   localparam int CLR_AW = $clog2(CLR_N)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  pcnc_pkg::op_type  op,
   input  logic              clr_en,
   input  logic [CLR_AW-1:0] clr_addr,
   output logic              s1_last,
   output logic              rsp_push,
   output pcnc_pkg::rsp_type rsp_data
);
   import pcnc_pkg::*;

   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int PART_AW = $clog2(PART_COUNT);

   logic             flag_mem [NODE_COUNT];
   logic [CNT_W-1:0] cnt_mem  [PART_COUNT];

   logic [31:0]        node_ext, part_ext, clr_ext;
   logic [NODE_AW-1:0] node_addr;
   logic [PART_AW-1:0] part_addr;
   logic               node_ok, part_ok;
   logic               clr_node_ok, clr_part_ok;

   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [NODE_AW-1:0] s1_node_ff;
   logic [PART_AW-1:0] s1_part_ff;
   logic               s1_node_ok_ff, s1_part_ok_ff;
   logic               flag_rd_ff;
   logic [CNT_W-1:0]   cnt_rd_ff;

   logic               rec_flag_we_ff, rec_cnt_we_ff;
   logic [NODE_AW-1:0] rec_node_ff;
   logic [PART_AW-1:0] rec_part_ff;
   logic [CNT_W-1:0]   rec_cnt_ff;

   logic [EDGE_W-1:0]  cut_edges_ff, cut_edges_in;
   logic [CNT_W-1:0]   cut_nodes_ff, cut_nodes_in;

   logic               flag_cur;
   logic [CNT_W-1:0]   cnt_cur, cnt_new;
   logic               do_mark, cnt_we;

   assign node_ext    = 32'(op.node);
   assign part_ext    = 32'(op.part);
   assign clr_ext     = 32'(clr_addr);
   assign node_addr   = node_ext[NODE_AW-1:0];
   assign part_addr   = part_ext[PART_AW-1:0];
   assign node_ok     = node_ext < 32'(NODE_COUNT);
   assign part_ok     = part_ext < 32'(PART_COUNT);
   assign clr_node_ok = clr_ext < 32'(NODE_COUNT);
   assign clr_part_ok = clr_ext < 32'(PART_COUNT);

   // Read port: one flag and one counter per cycle, registered.
   always_ff @(posedge clock) begin
      flag_rd_ff    <= flag_mem[node_addr];
      cnt_rd_ff     <= cnt_mem[part_addr];
      s1_op_ff      <= op;
      s1_node_ff    <= node_addr;
      s1_part_ff    <= part_addr;
      s1_node_ok_ff <= node_ok;
      s1_part_ok_ff <= part_ok;
   end

   // The read above misses only the write of the operation just ahead.
   always_comb begin
      flag_cur = flag_rd_ff;
      if (rec_flag_we_ff && rec_node_ff == s1_node_ff) begin
         flag_cur = 1'b1;
      end
      cnt_cur = cnt_rd_ff;
      if (rec_cnt_we_ff && rec_part_ff == s1_part_ff) begin
         cnt_cur = rec_cnt_ff;
      end
   end

   assign do_mark = s1_valid_ff && s1_op_ff.kind == OP_MARK && s1_node_ok_ff && !flag_cur;
   assign cnt_we  = do_mark && s1_part_ok_ff && cnt_cur != CNT_MAX;
   assign cnt_new = cnt_cur + 1'b1;

   always_comb begin
      cut_edges_in = cut_edges_ff;
      cut_nodes_in = cut_nodes_ff;
      if (s1_valid_ff && s1_op_ff.inc_edge && cut_edges_ff != EDGE_MAX) begin
         cut_edges_in = cut_edges_ff + 1'b1;
      end
      if (do_mark && cut_nodes_ff != CNT_MAX) begin
         cut_nodes_in = cut_nodes_ff + 1'b1;
      end
   end

   // Write port: the clearing pass, or the update of the operation in flight.
   always_ff @(posedge clock) begin
      if (clr_en) begin
         if (clr_node_ok) begin
            flag_mem[clr_addr[NODE_AW-1:0]] <= 1'b0;
         end
         if (clr_part_ok) begin
            cnt_mem[clr_addr[PART_AW-1:0]] <= '0;
         end
      end else begin
         if (do_mark) begin
            flag_mem[s1_node_ff] <= 1'b1;
         end
         if (cnt_we) begin
            cnt_mem[s1_part_ff] <= cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rec_flag_we_ff <= 1'b0;
         rec_cnt_we_ff  <= 1'b0;
         cut_edges_ff   <= '0;
         cut_nodes_ff   <= '0;
      end else begin
         s1_valid_ff    <= op_valid;
         rec_flag_we_ff <= do_mark;
         rec_cnt_we_ff  <= cnt_we;
         cut_edges_ff   <= cut_edges_in;
         cut_nodes_ff   <= cut_nodes_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_node_ff <= s1_node_ff;
      rec_part_ff <= s1_part_ff;
      rec_cnt_ff  <= cnt_new;
   end

   assign s1_last  = s1_valid_ff && s1_op_ff.last;
   assign rsp_push = s1_last;

   always_comb begin
      rsp_data                = '0;
      rsp_data.edge_is_cut    = s1_op_ff.is_cut;
      rsp_data.cut_edge_total = cut_edges_in;
      rsp_data.cut_node_total = cut_nodes_in;
      if (s1_op_ff.kind == OP_READ && s1_part_ok_ff) begin
         rsp_data.part_count = cnt_cur;
      end
   end

endmodule

// ===== hdl/pcnc_rsp_fifo.sv =====
// Small result queue that decouples the update stage from the receiver.
// Depends on pcnc_pkg and pcnc_rsp_if.
module pcnc_rsp_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pcnc_pkg::rsp_type           push_data,
   pcnc_rsp_if.source                  rsp_bus,
   output logic [pcnc_pkg::RSP_CW-1:0] count
);
   import pcnc_pkg::*;

   rsp_type           slots_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CW-1:0] count_ff, count_in;
   logic              pop;
   rsp_type           head;

   assign head                   = slots_ff[rd_ptr_ff];
   assign rsp_bus.valid          = count_ff != '0;
   assign rsp_bus.edge_is_cut    = head.edge_is_cut;
   assign rsp_bus.cut_edge_total = head.cut_edge_total;
   assign rsp_bus.cut_node_total = head.cut_node_total;
   assign rsp_bus.part_count     = head.part_count;
   assign pop                    = rsp_bus.valid && rsp_bus.ready;
   assign count                  = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/partition_cut_node_counter_core.sv =====
// Partition cut-node counter: counts cut edges and distinct cut nodes of a
// graph whose edges arrive as request beats on req_bus, one beat per edge or
// per read of a partition's cut-node count. Every request beat yields exactly
// one response beat on rsp_bus, in order, carrying the cut flag, the running
// cut-edge and cut-node totals, and on reads the requested partition count.
// A cut edge becomes two memory operations, source endpoint first, since its
// two endpoints share the single read port and the single write port of the
// node flag and partition counter memories; uncut edges and reads become one.
// The next request beat is taken as the last operation of the held one issues.
// After reset the block runs a clearing pass over max(NODE_COUNT, PART_COUNT)
// addresses (65536 by default), one memory entry per cycle, and holds
// req_bus.ready low until it is done.
// When the receiver stalls, up to four responses wait in a queue and the
// block keeps taking request beats until that queue would overflow.
// Depends on pcnc_pkg, the channel interfaces, pcnc_seq, pcnc_rmw and
// pcnc_rsp_fifo.
module partition_cut_node_counter_core #(
   parameter int NODE_COUNT = 65536,
   parameter int PART_COUNT = 64
) (
   input  logic       clock,
   input  logic       reset,
   pcnc_req_if.sink   req_bus,
   pcnc_rsp_if.source rsp_bus
);
   import pcnc_pkg::*;

   localparam int CLR_N  = (NODE_COUNT > PART_COUNT) ? NODE_COUNT : PART_COUNT;
   localparam int CLR_AW = $clog2(CLR_N);

   // Operations from the sequencer to the memory stage.
   logic              op_valid;
   op_type            op;
   logic              clr_en;
   logic [CLR_AW-1:0] clr_addr;

   // Results into the queue, and the back-pressure that returns from it.
   logic              s1_last;
   logic              rsp_push;
   rsp_type           rsp_data;
   logic [RSP_CW-1:0] fifo_count;

   // The sequencer holds one beat and issues one memory operation per cycle while
   // the queue has room, two for a cut edge (source endpoint first, then destination).
   pcnc_seq #(
      .NODE_COUNT (NODE_COUNT),
      .PART_COUNT (PART_COUNT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .fifo_count (fifo_count),
      .s1_last    (s1_last),
      .op_valid   (op_valid),
      .op         (op),
      .clr_en     (clr_en),
      .clr_addr   (clr_addr)
   );

   // The memory stage reads the flag and counter in one cycle and writes them
   // back in the next, forwarding its last write to the operation behind it,
   // which covers self loops and repeated nodes or partitions.
   pcnc_rmw #(
      .NODE_COUNT (NODE_COUNT),
      .PART_COUNT (PART_COUNT)
   ) u_rmw (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .clr_en    (clr_en),
      .clr_addr  (clr_addr),
      .s1_last   (s1_last),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // The queue parts the response side from the work, so a stalled receiver
   // does not stop request beats until the queue fills.
   pcnc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .rsp_bus   (rsp_bus),
      .count     (fifo_count)
   );

endmodule
